FILE: design/utf8_to_utf16_transcoder_unit_defines.svh
// Assertion macros shared by the transcoder RTL.
// Depends on: nothing; users provide clk and rst_n in scope.
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define U2U_CHECK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define U2U_CHECK_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/u2u_pkg.sv
// Types and constants of the UTF-8 to UTF-16 transcoder.
// Depends on: nothing.
`default_nettype none

package u2u_pkg;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_ASCII  = 2'd1,
        OP_REPL   = 2'd2,
        OP_FINISH = 2'd3
    } u2u_op_t;

    // Decoded work for the back end: an optional leading replacement unit
    // (broken sequence) and then the unit(s) of the operation.
    typedef struct packed {
        logic       pre_repl;
        u2u_op_t    op;
        logic [2:0] len;
        logic [20:0] cp;
    } u2u_cmd_t;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] MAX_CP      = 21'h10FFFF;
    localparam logic [20:0] BMP_LAST    = 21'h00FFFF;
    localparam logic [20:0] MIN_CP2     = 21'h000080;
    localparam logic [20:0] MIN_CP3     = 21'h000800;
    localparam logic [20:0] MIN_CP4     = 21'h010000;
    localparam logic [2:0]  SEQ_NONE    = 3'd0;
    localparam logic [2:0]  SEQ_LEN2    = 3'd2;
    localparam logic [2:0]  SEQ_LEN3    = 3'd3;
    localparam logic [2:0]  SEQ_LEN4    = 3'd4;

endpackage

`default_nettype wire

FILE: design/u2u_front.sv
// Front end: takes bytes, tracks the open UTF-8 sequence, issues decode commands.
// Depends on: u2u_pkg.
`default_nettype none

module u2u_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          byte_value,
    input  wire logic                queue_full,
    output logic                     push,
    output u2u_pkg::u2u_cmd_t        push_cmd
);

    logic [2:0]  seq_len_reg, seq_len_next;
    logic [2:0]  seen_reg, seen_next;
    logic [20:0] accum_reg, accum_next;
    logic        accept;
    logic        is_cont;
    logic [20:0] cont_accum;
    logic [2:0]  cont_seen;
    u2u_pkg::u2u_cmd_t cmd;

    assign in_ready   = !queue_full;
    assign accept     = in_valid && in_ready;
    assign is_cont    = (byte_value[7:6] == 2'b10);
    assign cont_accum = {accum_reg[14:0], byte_value[5:0]};
    assign cont_seen  = seen_reg + 3'd1;

    always_comb
    begin
        cmd          = '0;
        cmd.op       = u2u_pkg::OP_NONE;
        seq_len_next = seq_len_reg;
        seen_next    = seen_reg;
        accum_next   = accum_reg;
        if ((seq_len_reg != u2u_pkg::SEQ_NONE) && is_cont)
        begin
            accum_next = cont_accum;
            seen_next  = cont_seen;
            if (cont_seen >= seq_len_reg)
            begin
                cmd.op       = u2u_pkg::OP_FINISH;
                cmd.len      = seq_len_reg;
                cmd.cp       = cont_accum;
                seq_len_next = u2u_pkg::SEQ_NONE;
                seen_next    = '0;
                accum_next   = '0;
            end
        end
        else
        begin
            cmd.pre_repl = (seq_len_reg != u2u_pkg::SEQ_NONE);
            seq_len_next = u2u_pkg::SEQ_NONE;
            seen_next    = '0;
            accum_next   = '0;
            priority if (byte_value == 8'h00)
            begin
                cmd.op = u2u_pkg::OP_NONE;
            end
            else if (byte_value[7] == 1'b0)
            begin
                cmd.op = u2u_pkg::OP_ASCII;
                cmd.cp = {13'd0, byte_value};
            end
            else if (byte_value[7:5] == 3'b110)
            begin
                seq_len_next = u2u_pkg::SEQ_LEN2;
                seen_next    = 3'd1;
                accum_next   = {16'd0, byte_value[4:0]};
            end
            else if (byte_value[7:4] == 4'b1110)
            begin
                seq_len_next = u2u_pkg::SEQ_LEN3;
                seen_next    = 3'd1;
                accum_next   = {17'd0, byte_value[3:0]};
            end
            else if (byte_value[7:3] == 5'b11110)
            begin
                seq_len_next = u2u_pkg::SEQ_LEN4;
                seen_next    = 3'd1;
                accum_next   = {18'd0, byte_value[2:0]};
            end
            else
            begin
                cmd.op = u2u_pkg::OP_REPL;
            end
        end
    end

    assign push     = accept && (cmd.pre_repl || (cmd.op != u2u_pkg::OP_NONE));
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= u2u_pkg::SEQ_NONE;
            seen_reg    <= '0;
            accum_reg   <= '0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            seen_reg    <= seen_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/u2u_queue.sv
// Command queue between front and back end.
// Depends on: u2u_pkg, utf8_to_utf16_transcoder_unit_defines.svh.
`default_nettype none

`include "utf8_to_utf16_transcoder_unit_defines.svh"

module u2u_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire u2u_pkg::u2u_cmd_t   push_cmd,
    input  wire logic                pop,
    output u2u_pkg::u2u_cmd_t        head_cmd,
    output logic                     full,
    output logic                     empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u_pkg::u2u_cmd_t entry_reg [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `U2U_CHECK(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count above depth")
    `U2U_CHECK(a_no_overflow, push |-> (!full || pop), "push into full queue")
    `U2U_CHECK(a_no_underflow, pop |-> !empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: design/u2u_back.sv
// Back end: validates finished code points, forms UTF-16 units, drives the output register.
// Depends on: u2u_pkg, utf8_to_utf16_transcoder_unit_defines.svh.
`default_nettype none

`include "utf8_to_utf16_transcoder_unit_defines.svh"

module u2u_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire u2u_pkg::u2u_cmd_t   head_cmd,
    input  wire logic                head_valid,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [15:0]              code_unit,
    output logic                     last_unit
);

    logic        out_valid_reg, out_valid_next;
    logic        sel_reg, sel_next;
    logic [15:0] code_unit_reg, code_unit_next;
    logic        last_unit_reg, last_unit_next;

    logic [20:0] min_cp;
    logic [20:0] off;
    logic        fin_bad;
    logic        fin_pair;
    logic [15:0] fin_u0;
    logic [15:0] fin_u1;
    logic [15:0] op_unit;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        two_units;
    logic        unit_last;
    logic        load;

    always_comb
    begin
        unique case (head_cmd.len)
            u2u_pkg::SEQ_LEN2: min_cp = u2u_pkg::MIN_CP2;
            u2u_pkg::SEQ_LEN3: min_cp = u2u_pkg::MIN_CP3;
            default:           min_cp = u2u_pkg::MIN_CP4;
        endcase
    end

    assign off      = head_cmd.cp - u2u_pkg::MIN_CP4;
    assign fin_bad  = (head_cmd.cp < min_cp)
                   || ((head_cmd.cp >= u2u_pkg::SURR_FIRST) && (head_cmd.cp <= u2u_pkg::SURR_LAST))
                   || (head_cmd.cp > u2u_pkg::MAX_CP);
    assign fin_pair = (head_cmd.cp > u2u_pkg::BMP_LAST);
    assign fin_u0   = fin_bad  ? u2u_pkg::REPLACEMENT
                    : fin_pair ? {u2u_pkg::HI_SURR_TAG, off[19:10]}
                    : head_cmd.cp[15:0];
    assign fin_u1   = {u2u_pkg::LO_SURR_TAG, off[9:0]};

    always_comb
    begin
        unique case (head_cmd.op)
            u2u_pkg::OP_ASCII:  op_unit = {8'h00, head_cmd.cp[7:0]};
            u2u_pkg::OP_FINISH: op_unit = fin_u0;
            default:            op_unit = u2u_pkg::REPLACEMENT;
        endcase
    end

    always_comb
    begin
        if (head_cmd.pre_repl)
        begin
            unit0     = u2u_pkg::REPLACEMENT;
            unit1     = op_unit;
            two_units = (head_cmd.op != u2u_pkg::OP_NONE);
        end
        else
        begin
            unit0     = op_unit;
            unit1     = fin_u1;
            two_units = (head_cmd.op == u2u_pkg::OP_FINISH) && !fin_bad && fin_pair;
        end
    end

    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign unit_last = !two_units || sel_reg;
    assign pop       = load && unit_last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        sel_next       = sel_reg;
        code_unit_next = code_unit_reg;
        last_unit_next = last_unit_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            sel_next       = !unit_last;
            code_unit_next = sel_reg ? unit1 : unit0;
            last_unit_next = unit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_unit_reg <= code_unit_next;
        last_unit_reg <= last_unit_next;
    end

    assign out_valid = out_valid_reg;
    assign code_unit = code_unit_reg;
    assign last_unit = last_unit_reg;

    `U2U_CHECK_ALWAYS(a_reset_idle, !rst_n |-> !out_valid_reg, "output valid during reset")
    `U2U_CHECK(a_sel_first_unit, sel_reg |-> (out_valid_reg && !last_unit_reg),
               "second unit pending without first unit shown")
    `U2U_CHECK(a_high_surr_not_last,
               (out_valid_reg && (code_unit_reg[15:10] == u2u_pkg::HI_SURR_TAG)) |-> !last_unit_reg,
               "high surrogate marked as last unit")

endmodule

`default_nettype wire

FILE: design/utf8_to_utf16_transcoder_unit.sv
// A byte's first code unit is written to the command queue when the byte transfers and is
// then registered in the output register, from which it transfers out.
// Throughput: one byte per cycle while the command queue is not full; a surrogate pair,
// or a replacement followed by a new unit, leaves the output register one unit per transfer.
// The front end stalls only when the command queue (QUEUE_DEPTH entries) is full.
// Reset (rst_n low, asynchronous) closes any open sequence and empties queue and output.
`default_nettype none

module utf8_to_utf16_transcoder_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      code_unit,
    output logic             last_unit
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    u2u_pkg::u2u_cmd_t push_cmd;
    u2u_pkg::u2u_cmd_t head_cmd;

    u2u_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    u2u_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (!queue_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_unit  (code_unit),
        .last_unit  (last_unit)
    );

endmodule

`default_nettype wire
